FILE: hw/rtl/dlepd_pkg.sv
package dlepd_pkg;

  localparam int MAX_INDEX_DEF = 255;

  localparam logic [7:0] DLE_BYTE = 8'h10;
  localparam logic [7:0] ETX_BYTE = 8'h03;

  localparam logic [1:0] EV_START   = 2'd0;
  localparam logic [1:0] EV_PAYLOAD = 2'd1;
  localparam logic [1:0] EV_END     = 2'd2;

  typedef enum logic [2:0] {
    MODE_IDLE     = 3'd0,
    MODE_HDR      = 3'd1,
    MODE_HUNT     = 3'd2,
    MODE_HUNT_DLE = 3'd3,
    MODE_DATA     = 3'd4,
    MODE_DATA_DLE = 3'd5
  } mode_t;

  typedef struct packed {
    logic [1:0] event_res;
    logic [7:0] data_byte;
    logic [7:0] report_id;
    logic [7:0] byte_index;
    logic       last;
  } res_t;

endpackage

FILE: hw/rtl/dlepd_if.sv
interface dlepd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface dlepd_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] event_res;
  logic [7:0] data_byte;
  logic [7:0] report_id;
  logic [7:0] byte_index;
  logic       last;

  modport source (output valid, output event_res, output data_byte, output report_id,
                  output byte_index, output last, input ready);
  modport sink   (input valid, input event_res, input data_byte, input report_id,
                  input byte_index, input last, output ready);
endinterface

FILE: hw/rtl/dle_packet_deframer.sv
// Channel  Dir  Payload                                              Handshake
// rx       in   rx_byte[7:0]                                         valid/ready
// res      out  event_res[1:0] data_byte report_id byte_index last   valid/ready
//
// One byte is decoded in the cycle it is accepted; its results are registered into a
// three-entry result queue, whose head entry drives res.
// Sustained rate is one byte per cycle while res is ready; a DLE followed by a byte
// other than DLE or ETX yields two payload results, sent one at a time on res.
// rx.ready is high while the queue keeps two free entries after this cycle's pop.
// Synchronous reset returns to idle (expecting header DLE) and empties the queue.
module dle_packet_deframer #(
  parameter int MAX_INDEX = dlepd_pkg::MAX_INDEX_DEF
) (
  input logic         clk,
  input logic         rst,
  dlepd_in_if.sink    rx,
  dlepd_out_if.source res
);

  localparam int CntW = $clog2(MAX_INDEX + 1);
  localparam logic [CntW-1:0] CntMax = CntW'(MAX_INDEX);

  dlepd_pkg::mode_t mode, mode_next;
  logic [7:0]       cur_id, cur_id_next;
  logic [CntW-1:0]  count, count_next, count_inc, count_inc2;

  dlepd_pkg::res_t  q [3];
  dlepd_pkg::res_t  q_next [3];
  logic [1:0]       qcnt, qcnt_next, avail;
  logic             pop, take;

  dlepd_pkg::res_t  r0, r1;
  logic [1:0]       n_new;

  always_comb begin
    count_inc  = (count < CntMax) ? count + 1'b1 : count;
    count_inc2 = (count_inc < CntMax) ? count_inc + 1'b1 : count_inc;
  end

  always_comb begin
    logic [7:0] b;
    b           = rx.rx_byte;
    mode_next   = mode;
    cur_id_next = cur_id;
    count_next  = count;
    n_new       = 2'd0;
    r0          = '{event_res: dlepd_pkg::EV_PAYLOAD, data_byte: b, report_id: cur_id,
                    byte_index: 8'(count), last: 1'b1};
    r1          = '{event_res: dlepd_pkg::EV_PAYLOAD, data_byte: b, report_id: cur_id,
                    byte_index: 8'(count_inc), last: 1'b1};
    case (mode)
      dlepd_pkg::MODE_HDR: begin
        if (b == dlepd_pkg::DLE_BYTE) begin
          mode_next = dlepd_pkg::MODE_HUNT;
        end else if (b == dlepd_pkg::ETX_BYTE) begin
          mode_next = dlepd_pkg::MODE_IDLE;
        end else begin
          cur_id_next  = b;
          count_next   = '0;
          r0.event_res = dlepd_pkg::EV_START;
          r0.report_id = b;
          r0.byte_index = 8'd0;
          n_new        = 2'd1;
          mode_next    = dlepd_pkg::MODE_DATA;
        end
      end
      dlepd_pkg::MODE_HUNT: begin
        if (b == dlepd_pkg::DLE_BYTE) begin
          mode_next = dlepd_pkg::MODE_HUNT_DLE;
        end
      end
      dlepd_pkg::MODE_HUNT_DLE: begin
        mode_next = (b == dlepd_pkg::ETX_BYTE) ? dlepd_pkg::MODE_IDLE : dlepd_pkg::MODE_HUNT;
      end
      dlepd_pkg::MODE_DATA: begin
        if (b == dlepd_pkg::DLE_BYTE) begin
          mode_next = dlepd_pkg::MODE_DATA_DLE;
        end else begin
          count_next = count_inc;
          n_new      = 2'd1;
        end
      end
      dlepd_pkg::MODE_DATA_DLE: begin
        mode_next = dlepd_pkg::MODE_DATA;
        if (b == dlepd_pkg::DLE_BYTE) begin
          r0.data_byte = dlepd_pkg::DLE_BYTE;
          count_next   = count_inc;
          n_new        = 2'd1;
        end else if (b == dlepd_pkg::ETX_BYTE) begin
          r0.event_res = dlepd_pkg::EV_END;
          r0.data_byte = 8'd0;
          n_new        = 2'd1;
          mode_next    = dlepd_pkg::MODE_IDLE;
        end else begin
          r0.data_byte = dlepd_pkg::DLE_BYTE;
          r0.last      = 1'b0;
          count_next   = count_inc2;
          n_new        = 2'd2;
        end
      end
      default: begin
        mode_next = (b == dlepd_pkg::DLE_BYTE) ? dlepd_pkg::MODE_HDR : dlepd_pkg::MODE_HUNT;
      end
    endcase
  end

  always_comb begin
    pop      = res.valid && res.ready;
    avail    = qcnt - {1'b0, pop};
    rx.ready = (avail <= 2'd1);
    take     = rx.valid && rx.ready;

    q_next = q;
    if (pop) begin
      q_next[0] = q[1];
      q_next[1] = q[2];
    end
    qcnt_next = avail;
    if (take) begin
      qcnt_next = avail + n_new;
      if (n_new != 2'd0) begin
        q_next[avail] = r0;
      end
      if (n_new == 2'd2) begin
        q_next[2'(avail + 2'd1)] = r1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode   <= dlepd_pkg::MODE_IDLE;
      cur_id <= '0;
      count  <= '0;
      qcnt   <= '0;
    end else begin
      qcnt <= qcnt_next;
      if (take) begin
        mode   <= mode_next;
        cur_id <= cur_id_next;
        count  <= count_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    q <= q_next;
  end

  assign res.valid      = (qcnt != 2'd0);
  assign res.event_res  = q[0].event_res;
  assign res.data_byte  = q[0].data_byte;
  assign res.report_id  = q[0].report_id;
  assign res.byte_index = q[0].byte_index;
  assign res.last       = q[0].last;

endmodule

FILE: hw/rtl/dlepd_checker.sv
module dlepd_checker (
  input logic       clk,
  input logic       rst,
  input logic       res_valid,
  input logic       res_ready,
  input logic [1:0] event_res,
  input logic [7:0] data_byte,
  input logic [7:0] report_id,
  input logic [7:0] byte_index,
  input logic       last
);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(event_res) && $stable(data_byte)
      && $stable(report_id) && $stable(byte_index) && $stable(last))
    else $error("stalled result changed");

  a_pair: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_ready && !last |=> res_valid && last
      && event_res == dlepd_pkg::EV_PAYLOAD)
    else $error("second result of a pair missing");

  a_start: assert property (@(posedge clk) disable iff (rst)
    res_valid && event_res == dlepd_pkg::EV_START |->
      last && byte_index == 8'd0 && data_byte == report_id)
    else $error("bad packet start");

  a_end: assert property (@(posedge clk) disable iff (rst)
    res_valid && event_res == dlepd_pkg::EV_END |-> last && data_byte == 8'd0)
    else $error("bad packet end");

endmodule

bind dle_packet_deframer dlepd_checker u_dlepd_checker (
  .clk        (clk),
  .rst        (rst),
  .res_valid  (res.valid),
  .res_ready  (res.ready),
  .event_res  (res.event_res),
  .data_byte  (res.data_byte),
  .report_id  (res.report_id),
  .byte_index (res.byte_index),
  .last       (res.last)
);
